>>> rtl/linear_probe_hash_table_macros.svh
// ----------------------------------------------------------------------------
// linear probe hash table assertion macros
// concurrent assertion helpers clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// plain property, checked at every edge out of reset
`define LPHT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants, codes and types of the linear probe hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int CAPACITY_DEF      = 64;
	localparam int MAX_KEY_WORDS_DEF = 4;
	localparam int IN_WORDS          = 4;
	localparam int WORD_W            = 64;
	localparam int LEN_W             = 3;
	localparam int META_W            = 1 + LEN_W + WORD_W;
	localparam int HASH_BITS         = 31;
	localparam int HORNER_SHIFT      = 5;

	// commands
	localparam logic [2:0] CMD_PUT      = 3'd0;
	localparam logic [2:0] CMD_GET      = 3'd1;
	localparam logic [2:0] CMD_CONT_KEY = 3'd2;
	localparam logic [2:0] CMD_REMOVE   = 3'd3;
	localparam logic [2:0] CMD_ADD      = 3'd4;
	localparam logic [2:0] CMD_CONTAINS = 3'd5;
	localparam logic [2:0] CMD_CLEAR    = 3'd6;

	// status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_KIND = 2'd3;

	// table kinds
	localparam logic KIND_MAP = 1'b0;
	localparam logic KIND_SET = 1'b1;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
	} hash_req_t;

endpackage

>>> rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash
// iterative horner-31 hash, one key word per cycle, then start slot reduction
// ----------------------------------------------------------------------------
module lpht_hash #(
	parameter int CAPACITY      = lpht_pkg::CAPACITY_DEF,
	parameter int MAX_KEY_WORDS = lpht_pkg::MAX_KEY_WORDS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  lpht_pkg::hash_req_t                             req,
	input  logic [MAX_KEY_WORDS-1:0][lpht_pkg::WORD_W-1:0]  key,
	output logic                                            done,
	output logic [$clog2(CAPACITY)-1:0]                     slot
);

	localparam int SW      = $clog2(CAPACITY);
	localparam int KW_W    = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
	localparam int HB      = lpht_pkg::HASH_BITS;
	localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
	// floor(2^32 / capacity), quotient estimate is low by at most one
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));

	typedef enum logic [2:0] {H_IDLE, H_MIX, H_MOD, H_RED, H_FIX} hstate_t;

	hstate_t                       state_q;
	logic [lpht_pkg::WORD_W-1:0]   h_q;
	logic [lpht_pkg::LEN_W-1:0]    i_q;
	logic [lpht_pkg::LEN_W-1:0]    len_q;
	logic [30:0]                   q_q;
	logic [31:0]                   rem_q;
	logic [SW-1:0]                 slot_q;
	logic                          done_q;
	logic [62:0]                   prod;

	// reciprocal quotient of the masked hash
	assign prod = 63'(h_q[HB-1:0]) * 63'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == H_MOD && IS_POW2) || (state_q == H_FIX);
			unique case (state_q)
				H_IDLE: begin
					if (req.start) begin
						h_q     <= 64'd1;
						i_q     <= '0;
						len_q   <= req.len;
						state_q <= H_MIX;
					end
				end
				H_MIX: begin
					h_q <= (h_q << lpht_pkg::HORNER_SHIFT) - h_q + key[i_q[KW_W-1:0]];
					if (i_q == len_q - 3'd1) begin
						state_q <= H_MOD;
					end else begin
						i_q <= i_q + 3'd1;
					end
				end
				H_MOD: begin
					if (IS_POW2) begin
						slot_q  <= h_q[SW-1:0];
						state_q <= H_IDLE;
					end else begin
						q_q     <= prod[62:32];
						state_q <= H_RED;
					end
				end
				H_RED: begin
					rem_q   <= 32'(h_q[HB-1:0]) - 32'(q_q) * 32'(CAPACITY);
					state_q <= H_FIX;
				end
				H_FIX: begin
					slot_q  <= (rem_q >= 32'(CAPACITY)) ?
						SW'(rem_q - 32'(CAPACITY)) : SW'(rem_q);
					state_q <= H_IDLE;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign slot = slot_q;

endmodule

>>> rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash table with linear probing, tuple keys of up to four
// 64-bit words, map or set kind, removal by cluster reinsertion
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  cfg       cfg_valid/cfg_ready    cfg_data (table kind)
//  in        in_valid/in_stall      command, key_length, key_word_0..3, store_value
//  out       out_valid/out_stall    status, hit, data_out, entry_count
//
//  one item at a time; a command hashes its key, then probes slot by slot,
//  comparing key words where the key length matches, and an insert writes
//  every key word of its slot
//  remove additionally reinserts each following cluster entry (read, hash, probe, fill)
//  clear and the pass after reset sweep the slot state, one slot per cycle;
//  no item is taken during the sweep
//  the result sits in an output register, so a stalled result does not keep
//  the next item from being taken
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table #(
	parameter int CAPACITY      = lpht_pkg::CAPACITY_DEF,
	parameter int MAX_KEY_WORDS = lpht_pkg::MAX_KEY_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [2:0]         key_length,
	input  logic signed [63:0] key_word_0,
	input  logic signed [63:0] key_word_1,
	input  logic signed [63:0] key_word_2,
	input  logic signed [63:0] key_word_3,
	input  logic [63:0]        store_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               hit,
	output logic [63:0]        data_out,
	output logic [6:0]         entry_count
);

	localparam int SW        = $clog2(CAPACITY);
	localparam int CW        = $clog2(CAPACITY + 1);
	localparam int KW_W      = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
	localparam int KA_W      = SW + KW_W;
	localparam int KDEPTH    = CAPACITY << KW_W;
	localparam int LIMIT     = (CAPACITY * 3) / 4;
	localparam int KEY_LIMIT = (MAX_KEY_WORDS < lpht_pkg::IN_WORDS) ?
		MAX_KEY_WORDS : lpht_pkg::IN_WORDS;
	localparam int WW        = lpht_pkg::WORD_W;
	localparam int LW        = lpht_pkg::LEN_W;
	localparam int MW        = lpht_pkg::META_W;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DEC, S_HASH, S_HWAIT, S_PRD, S_PCHK, S_PWCHK,
		S_ACT, S_FILL, S_RRD, S_RCHK, S_RKRD, S_RKLD, S_RESP
	} state_t;

	typedef enum logic [1:0] {PR_NONE, PR_FREE, PR_FOUND} probe_t;

	state_t                          state_q;
	probe_t                          pres_q;
	logic                            kind_q;
	logic                            reins_q;
	logic                            clr_resp_q;
	logic [SW-1:0]                   clr_q;
	logic [CW-1:0]                   count_q;
	logic [2:0]                      cmd_q;
	logic [LW-1:0]                   cur_len_q;
	logic [MAX_KEY_WORDS-1:0][WW-1:0] cur_key_q;
	logic [WW-1:0]                   fval_q;
	logic [SW-1:0]                   idx_q;
	logic [SW-1:0]                   p_q;
	logic [SW-1:0]                   n_q;
	logic [KW_W-1:0]                 w_q;
	logic [1:0]                      res_status_q;
	logic                            res_hit_q;
	logic [WW-1:0]                   res_data_q;
	logic                            out_valid_q;
	logic [1:0]                      status_q;
	logic                            hit_q;
	logic [WW-1:0]                   data_q;
	logic [6:0]                      entry_q;

	logic [lpht_pkg::IN_WORDS-1:0][WW-1:0] key_in;
	logic [LW-1:0]                   len_in;
	lpht_pkg::hash_req_t             hreq;
	logic                            hash_done;
	logic [SW-1:0]                   hash_slot;

	// slot state ram: used bit, key length, value
	logic                            m_we;
	logic [SW-1:0]                   m_waddr;
	logic [MW-1:0]                   m_wdata;
	logic                            m_re;
	logic [SW-1:0]                   m_raddr;
	logic [MW-1:0]                   m_rdata;
	logic                            m_used;
	logic [LW-1:0]                   m_len;
	logic [WW-1:0]                   m_val;

	// key word ram, addressed {slot, word}
	logic                            k_we;
	logic [KA_W-1:0]                 k_waddr;
	logic [WW-1:0]                   k_wdata;
	logic                            k_re;
	logic [KA_W-1:0]                 k_raddr;
	logic [WW-1:0]                   k_rdata;

	logic [SW-1:0]                   idx_nx;
	logic [SW-1:0]                   p_nx;
	logic                            w_last;
	logic                            w_len_last;
	logic                            wrong_kind;

	assign key_in = {key_word_3, key_word_2, key_word_1, key_word_0};

	// zero length counts as one, long keys saturate
	always_comb begin
		len_in = key_length;
		if (key_length == 3'd0) begin
			len_in = 3'd1;
		end else if (key_length > LW'(KEY_LIMIT)) begin
			len_in = LW'(KEY_LIMIT);
		end
	end

	assign {m_used, m_len, m_val} = m_rdata;
	assign idx_nx     = (idx_q == SW'(CAPACITY - 1)) ? '0 : idx_q + 1'b1;
	assign p_nx       = (p_q == SW'(CAPACITY - 1)) ? '0 : p_q + 1'b1;
	assign w_last     = (w_q == KW_W'(MAX_KEY_WORDS - 1));
	assign w_len_last = (4'(w_q) + 4'd1 == 4'(cur_len_q));

	// put/get need map kind, add/contains need set kind; undefined code too
	always_comb begin
		wrong_kind = 1'b0;
		unique case (cmd_q)
			lpht_pkg::CMD_PUT, lpht_pkg::CMD_GET:   wrong_kind = (kind_q != lpht_pkg::KIND_MAP);
			lpht_pkg::CMD_ADD, lpht_pkg::CMD_CONTAINS: wrong_kind = (kind_q != lpht_pkg::KIND_SET);
			lpht_pkg::CMD_CONT_KEY, lpht_pkg::CMD_REMOVE, lpht_pkg::CMD_CLEAR: wrong_kind = 1'b0;
			default: wrong_kind = 1'b1;
		endcase
	end

	assign hreq.start = (state_q == S_HASH);
	assign hreq.len   = cur_len_q;

	lpht_hash #(
		.CAPACITY     (CAPACITY),
		.MAX_KEY_WORDS(MAX_KEY_WORDS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hreq),
		.key   (cur_key_q),
		.done  (hash_done),
		.slot  (hash_slot)
	);

	// ram port steering
	always_comb begin
		m_we    = 1'b0;
		m_waddr = idx_q;
		m_wdata = {1'b1, cur_len_q, fval_q};
		m_re    = 1'b0;
		m_raddr = idx_q;
		k_we    = 1'b0;
		k_waddr = {idx_q, w_q};
		k_wdata = (4'(w_q) < 4'(cur_len_q)) ? cur_key_q[w_q] : '0;
		k_re    = 1'b0;
		k_raddr = {idx_q, {KW_W{1'b0}}};
		unique case (state_q)
			S_CLR: begin
				m_we    = 1'b1;
				m_waddr = clr_q;
				m_wdata = '0;
			end
			S_PRD: m_re = 1'b1;
			S_PCHK: k_re = 1'b1;
			S_PWCHK: begin
				k_re    = 1'b1;
				k_raddr = {idx_q, w_q + 1'b1};
			end
			S_ACT: begin
				// put hit rewrites the value, remove hit frees the slot
				if (!reins_q && pres_q == PR_FOUND) begin
					if (cmd_q == lpht_pkg::CMD_PUT) begin
						m_we = 1'b1;
					end else if (cmd_q == lpht_pkg::CMD_REMOVE) begin
						m_we    = 1'b1;
						m_wdata = '0;
					end
				end
			end
			S_FILL: begin
				k_we = 1'b1;
				m_we = w_last;
			end
			S_RRD: begin
				m_re    = 1'b1;
				m_raddr = p_q;
			end
			S_RCHK: begin
				m_we    = m_used;
				m_waddr = p_q;
				m_wdata = '0;
			end
			S_RKRD: begin
				k_re    = 1'b1;
				k_raddr = {p_q, {KW_W{1'b0}}};
			end
			S_RKLD: begin
				k_re    = 1'b1;
				k_raddr = {p_q, w_q + 1'b1};
			end
			default: ;
		endcase
	end

	lpht_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_meta_ram (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	lpht_ram #(.WIDTH(WW), .DEPTH(KDEPTH)) u_key_ram (
		.clk  (clk),
		.we   (k_we),
		.waddr(k_waddr),
		.wdata(k_wdata),
		.re   (k_re),
		.raddr(k_raddr),
		.rdata(k_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			clr_resp_q  <= 1'b0;
			count_q     <= '0;
			kind_q      <= lpht_pkg::KIND_MAP;
			out_valid_q <= 1'b0;
			reins_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				kind_q <= cfg_data;
			end
			// output transfer frees the register unless a new result lands
			if (out_valid_q && !out_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					if (clr_q == SW'(CAPACITY - 1)) begin
						clr_q   <= '0;
						state_q <= clr_resp_q ? S_RESP : S_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= command;
						cur_len_q <= len_in;
						for (int i = 0; i < MAX_KEY_WORDS; i++) begin
							cur_key_q[i] <= (i < lpht_pkg::IN_WORDS) ?
								key_in[i % lpht_pkg::IN_WORDS] : '0;
						end
						fval_q       <= (command == lpht_pkg::CMD_ADD) ? '0 : store_value;
						reins_q      <= 1'b0;
						res_status_q <= lpht_pkg::ST_DONE;
						res_hit_q    <= 1'b0;
						res_data_q   <= '0;
						state_q      <= S_DEC;
					end
				end
				S_DEC: begin
					if (wrong_kind) begin
						res_status_q <= lpht_pkg::ST_KIND;
						state_q      <= S_RESP;
					end else if (cmd_q == lpht_pkg::CMD_CLEAR) begin
						count_q    <= '0;
						clr_resp_q <= 1'b1;
						state_q    <= S_CLR;
					end else begin
						state_q <= S_HASH;
					end
				end
				S_HASH: state_q <= S_HWAIT;
				S_HWAIT: begin
					if (hash_done) begin
						idx_q   <= hash_slot;
						n_q     <= '0;
						state_q <= S_PRD;
					end
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					if (!m_used) begin
						pres_q  <= PR_FREE;
						state_q <= S_ACT;
					end else if (m_len == cur_len_q) begin
						w_q     <= '0;
						state_q <= S_PWCHK;
					end else if (n_q == SW'(CAPACITY - 1)) begin
						pres_q  <= PR_NONE;
						state_q <= S_ACT;
					end else begin
						n_q     <= n_q + 1'b1;
						idx_q   <= idx_nx;
						state_q <= S_PRD;
					end
				end
				S_PWCHK: begin
					if (k_rdata != cur_key_q[w_q]) begin
						if (n_q == SW'(CAPACITY - 1)) begin
							pres_q  <= PR_NONE;
							state_q <= S_ACT;
						end else begin
							n_q     <= n_q + 1'b1;
							idx_q   <= idx_nx;
							state_q <= S_PRD;
						end
					end else if (w_len_last) begin
						pres_q  <= PR_FOUND;
						state_q <= S_ACT;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_ACT: begin
					w_q <= '0;
					if (reins_q) begin
						// a moved entry always finds a free slot
						if (pres_q == PR_FREE) begin
							state_q <= S_FILL;
						end else begin
							p_q     <= p_nx;
							state_q <= S_RRD;
						end
					end else begin
						unique case (cmd_q)
							lpht_pkg::CMD_PUT, lpht_pkg::CMD_ADD: begin
								if (pres_q == PR_FOUND) begin
									res_hit_q <= 1'b1;
									if (cmd_q == lpht_pkg::CMD_PUT) begin
										res_data_q <= m_val;
									end else begin
										res_status_q <= lpht_pkg::ST_MISS;
									end
									state_q <= S_RESP;
								end else if (pres_q == PR_FREE && count_q < CW'(LIMIT)) begin
									state_q <= S_FILL;
								end else begin
									res_status_q <= lpht_pkg::ST_FULL;
									state_q      <= S_RESP;
								end
							end
							lpht_pkg::CMD_GET: begin
								state_q <= S_RESP;
								if (pres_q == PR_FOUND) begin
									res_hit_q  <= 1'b1;
									res_data_q <= m_val;
								end else begin
									res_status_q <= lpht_pkg::ST_MISS;
								end
							end
							lpht_pkg::CMD_REMOVE: begin
								if (pres_q == PR_FOUND) begin
									res_hit_q <= 1'b1;
									if (count_q != '0) begin
										count_q <= count_q - CW'(1);
									end
									p_q     <= idx_nx;
									reins_q <= 1'b1;
									state_q <= S_RRD;
								end else begin
									res_status_q <= lpht_pkg::ST_MISS;
									state_q      <= S_RESP;
								end
							end
							default: begin
								state_q <= S_RESP;
								if (pres_q == PR_FOUND) begin
									res_hit_q <= 1'b1;
								end else begin
									res_status_q <= lpht_pkg::ST_MISS;
								end
							end
						endcase
					end
				end
				S_FILL: begin
					if (w_last) begin
						count_q <= count_q + CW'(1);
						if (reins_q) begin
							p_q     <= p_nx;
							state_q <= S_RRD;
						end else begin
							state_q <= S_RESP;
						end
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_RRD: state_q <= S_RCHK;
				S_RCHK: begin
					// end of cluster closes the remove
					if (!m_used) begin
						state_q <= S_RESP;
					end else begin
						cur_len_q <= m_len;
						fval_q    <= m_val;
						if (count_q != '0) begin
							count_q <= count_q - CW'(1);
						end
						state_q <= S_RKRD;
					end
				end
				S_RKRD: begin
					w_q     <= '0;
					state_q <= S_RKLD;
				end
				S_RKLD: begin
					cur_key_q[w_q] <= k_rdata;
					if (w_last) begin
						state_q <= S_HASH;
					end else begin
						w_q <= w_q + 1'b1;
					end
				end
				S_RESP: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						hit_q       <= res_hit_q;
						data_q      <= res_data_q;
						entry_q     <= 7'(count_q);
						clr_resp_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign hit         = hit_q;
	assign data_out    = data_q;
	assign entry_count = entry_q;

	`LPHT_ASSERT(a_count_range, (count_q <= CW'(CAPACITY)), "occupied count beyond capacity")
	`LPHT_ASSERT_IMP(a_hash_when_waiting, hash_done, state_q == S_HWAIT, "hash done outside wait")
	`LPHT_ASSERT_IMP(a_fill_under_limit, (state_q == S_FILL && !reins_q), count_q < CW'(LIMIT), "fill past limit")
	`LPHT_ASSERT_IMP(a_kind_clean, (out_valid_q && status_q == lpht_pkg::ST_KIND), (!hit_q && data_q == '0), "kind result not clean")

endmodule
